// ===== hw/rtl/mbc_pkg.sv =====
// Shared types, constants and helper functions of the mirrored border convolution unit.
`timescale 1ns / 1ps
package mbc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_KERNEL = 7;

   localparam int DIM_W     = 11;
   localparam int KDIM_W    = 3;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int KI_W      = $clog2(MAX_KERNEL);
   localparam int SLOT_W    = $clog2(MAX_KERNEL);
   localparam int COORD_W   = DIM_W + 2;
   localparam int POS_W     = 2 * DIM_W;
   localparam int PIX_W     = 8;
   localparam int COEF_W    = 16;
   localparam int CIDX_W    = 6;
   localparam int PROD_W    = PIX_W + 1 + COEF_W;
   localparam int PSUM_W    = PROD_W + 3;
   localparam int ACC_W     = PROD_W + 7;
   localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int LINE_AW   = SLOT_W + COL_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = DIM_W;

   localparam logic [1:0] MODE_COEF  = 2'd0;
   localparam logic [1:0] MODE_PIXEL = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 2'd3;

   localparam logic [DIM_W-1:0]  RESET_WIDTH  = 11'd64;
   localparam logic [DIM_W-1:0]  RESET_HEIGHT = 11'd64;
   localparam logic [KDIM_W-1:0] RESET_KW     = 3'd3;
   localparam logic [KDIM_W-1:0] RESET_KH     = 3'd3;

   typedef struct packed {
      logic [1:0]               mode;
      logic [CIDX_W-1:0]        coef_index;
      logic signed [COEF_W-1:0] coef_value;
      logic [PIX_W-1:0]         pixel;
   } req_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic               last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic                     en;
      logic [KI_W-1:0]          row;
      logic [KI_W-1:0]          col;
      logic signed [COEF_W-1:0] value;
   } cwr_type;

   typedef struct packed {
      logic            en;
      logic [KI_W-1:0] row;
   } tap_type;

   function automatic logic [DIM_W-1:0] mirror(input logic signed [COORD_W-1:0] x,
                                               input logic [DIM_W-1:0] n);
      logic signed [COORD_W-1:0] nn;
      logic signed [COORD_W-1:0] m;
      begin
         nn = COORD_W'(n);
         if (x < 0) begin
            m = -x;
         end else if (x >= nn) begin
            m = (nn <<< 1) - COORD_W'(1) - x;
         end else begin
            m = x;
         end
         if (m < 0) begin
            m = '0;
         end
         if (m > nn - COORD_W'(1)) begin
            m = nn - COORD_W'(1);
         end
         return m[DIM_W-1:0];
      end
   endfunction

   // Remainder by seven: octal digits sum to the same residue.
   function automatic logic [SLOT_W-1:0] mod7(input logic [DIM_W-1:0] v);
      logic [4:0] s1;
      logic [3:0] s2;
      begin
         s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[10:9]);
         s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
         if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
         end
         return s2[SLOT_W-1:0];
      end
   endfunction

   function automatic logic [KI_W-1:0] coef_row(input logic [CIDX_W-1:0] idx);
      logic [KI_W-1:0] r;
      begin
         r = '0;
         for (int k = 1; k < MAX_KERNEL; k++) begin
            if (idx >= CIDX_W'(k * MAX_KERNEL)) begin
               r = r + KI_W'(1);
            end
         end
         return r;
      end
   endfunction

   function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0] t;
      logic signed [ACC_W:0] q;
      begin
         t = (ACC_W+1)'(acc) + (ACC_W+1)'(8192);
         q = t >>> 14;
         if (q > (ACC_W+1)'(32767)) begin
            return 16'sh7FFF;
         end else if (q < -(ACC_W+1)'(32768)) begin
            return 16'sh8000;
         end
         return q[15:0];
      end
   endfunction

endpackage

// ===== hw/rtl/mirrored_border_2d_convolution_unit.sv =====
// Top level of the mirrored border 2-D convolution unit: counters, tap sequencer and cell chain.
//
//   Channel  Ports                          Direction  Transfer when
//   req      req_valid/req_ready/req_data   in         req_valid && req_ready
//   rsp      rsp_valid/rsp_ready/rsp_data   out        rsp_valid && rsp_ready
//   csr      csr_we/csr_index/csr_wdata     in         csr_we
//
// Coefficient loads and pixels that draw no output leave the unit idle, so req_ready stays high.
// An item that draws an output holds req_ready low until its result is in the output register;
// the taps go through the single read port of the line store, one tap read per cycle,
// and none are read when either kernel size is zero.
// Reset is synchronous; the line store holds no reset and needs no clearing pass.
// A finished output waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module mirrored_border_2d_convolution_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mbc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mbc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [mbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbc_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import mbc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]  wid_ff, wid_in, hgt_ff, hgt_in;
   logic [KDIM_W-1:0] kw_ff, kw_in, kh_ff, kh_in;
   logic [DIM_W-1:0]  irow_ff, irow_in, icol_ff, icol_in;
   logic [DIM_W-1:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DIM_W-1:0]  cap_row_ff, cap_row_in, cap_col_ff, cap_col_in;
   logic              cap_last_ff, cap_last_in;
   logic [KI_W-1:0]   ti_ff, ti_in, tj_ff, tj_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic              fin_ff, fin_in;
   logic              b_valid_ff, b_end_ff, b_last_ff;
   logic [KI_W-1:0]   b_row_ff;
   logic              c_end_ff, c_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [KDIM_W-1:0] hh, hw;
   logic [POS_W-1:0]  delay;
   logic              req_fire, frame_done, pix_ok, emit, is_last, issue;
   logic signed [COORD_W-1:0] rcoord, ccoord;
   logic [DIM_W-1:0]  rm, cm;
   logic [LINE_AW-1:0] raddr, waddr;
   logic [PIX_W-1:0]  rdata;
   logic              out_free;
   cwr_type           cwr;
   tap_type           tap;
   logic signed [PSUM_W-1:0] chain [MAX_KERNEL+1];

   always_comb begin
      if (wid_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (wid_ff > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = wid_ff;
      end
      if (hgt_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (hgt_ff > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = hgt_ff;
      end
      hh = kh_ff >> 1;
      hw = kw_ff >> 1;
      delay = POS_W'(hh) * POS_W'(w_eff) + POS_W'(hw);
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign frame_done = (irow_ff >= h_eff);
   assign pix_ok     = (req_data.mode == MODE_PIXEL) && !frame_done;
   assign emit       = req_fire && ((pix_ok && pos_ff >= delay) ||
                                    (req_data.mode == MODE_FLUSH && frame_done));
   assign is_last    = (orow_ff == h_eff - DIM_W'(1)) && (ocol_ff == w_eff - DIM_W'(1));
   assign issue      = (state_ff == ST_RUN);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rcoord = COORD_W'(cap_row_ff) - COORD_W'(hh) + COORD_W'(ti_ff);
      ccoord = COORD_W'(cap_col_ff) - COORD_W'(hw) + COORD_W'(tj_ff);
      rm     = mirror(rcoord, h_eff);
      cm     = mirror(ccoord, w_eff);
      raddr  = {mod7(rm), cm[COL_W-1:0]};
      waddr  = {slot_ff, icol_ff[COL_W-1:0]};
   end

   always_comb begin
      cwr.en    = req_fire && (req_data.mode == MODE_COEF) &&
                  (req_data.coef_index < CIDX_W'(MAX_KERNEL * MAX_KERNEL));
      cwr.row   = coef_row(req_data.coef_index);
      cwr.col   = KI_W'(req_data.coef_index - CIDX_W'(cwr.row) * CIDX_W'(MAX_KERNEL));
      cwr.value = req_data.coef_value;
      tap.en    = b_valid_ff;
      tap.row   = b_row_ff;
   end

   mbc_ram #(
      .WIDTH(PIX_W),
      .DEPTH(LINE_DEPTH)
   ) u_line_store (
      .clock(clock),
      .we   (req_fire && pix_ok),
      .waddr(waddr),
      .wdata(req_data.pixel),
      .re   (issue),
      .raddr(raddr),
      .rdata(rdata)
   );

   assign chain[MAX_KERNEL] = '0;

   // The last active cell starts each kernel row from zero.
   for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_cell
      mbc_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .col_id        (KI_W'(k)),
         .active        (KDIM_W'(k) < kw_ff),
         .cwr           (cwr),
         .tap           (tap),
         .pixel_in      (rdata),
         .sum_from_right((KDIM_W'(k + 1) < kw_ff) ? chain[k+1] : '0),
         .sum_out       (chain[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      wid_in       = wid_ff;
      hgt_in       = hgt_ff;
      kw_in        = kw_ff;
      kh_in        = kh_ff;
      irow_in      = irow_ff;
      icol_in      = icol_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      slot_in      = slot_ff;
      pos_in       = pos_ff;
      cap_row_in   = cap_row_ff;
      cap_col_in   = cap_col_ff;
      cap_last_in  = cap_last_ff;
      ti_in        = ti_ff;
      tj_in        = tj_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (c_end_ff) begin
         acc_in = acc_ff + ACC_W'(chain[0]);
      end
      if (c_last_ff) begin
         fin_in = 1'b1;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   wid_in = csr_wdata;
            CSR_IMAGE_HEIGHT:  hgt_in = csr_wdata;
            CSR_KERNEL_WIDTH:  kw_in  = csr_wdata[KDIM_W-1:0];
            CSR_KERNEL_HEIGHT: kh_in  = csr_wdata[KDIM_W-1:0];
            default: ;
         endcase
         irow_in = '0;
         icol_in = '0;
         orow_in = '0;
         ocol_in = '0;
         slot_in = '0;
         pos_in  = '0;
      end else if (req_fire) begin
         if (pix_ok) begin
            pos_in = pos_ff + POS_W'(1);
            if (icol_ff + DIM_W'(1) >= w_eff) begin
               icol_in = '0;
               irow_in = irow_ff + DIM_W'(1);
               slot_in = (slot_ff == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_ff + SLOT_W'(1);
            end else begin
               icol_in = icol_ff + DIM_W'(1);
            end
         end
         if (emit) begin
            cap_row_in  = orow_ff;
            cap_col_in  = ocol_ff;
            cap_last_in = is_last;
            acc_in      = '0;
            ti_in       = '0;
            tj_in       = KI_W'(kw_ff - KDIM_W'(1));
            if (kw_ff == '0 || kh_ff == '0) begin
               fin_in   = 1'b1;
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_RUN;
            end
            if (is_last) begin
               irow_in = '0;
               icol_in = '0;
               orow_in = '0;
               ocol_in = '0;
               slot_in = '0;
               pos_in  = '0;
            end else if (ocol_ff + DIM_W'(1) >= w_eff) begin
               ocol_in = '0;
               orow_in = orow_ff + DIM_W'(1);
            end else begin
               ocol_in = ocol_ff + DIM_W'(1);
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: ;
         ST_RUN: begin
            if (tj_ff == '0) begin
               tj_in = KI_W'(kw_ff - KDIM_W'(1));
               if (ti_ff == KI_W'(kh_ff - KDIM_W'(1))) begin
                  state_in = ST_DRAIN;
               end else begin
                  ti_in = ti_ff + KI_W'(1);
               end
            end else begin
               tj_in = tj_ff - KI_W'(1);
            end
         end
         ST_DRAIN: begin
            if (fin_ff && out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.value          = round_sat(acc_ff);
               rsp_data_in.last_of_frame  = cap_last_ff;
               fin_in                     = 1'b0;
               state_in                   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wid_ff       <= RESET_WIDTH;
         hgt_ff       <= RESET_HEIGHT;
         kw_ff        <= RESET_KW;
         kh_ff        <= RESET_KH;
         irow_ff      <= '0;
         icol_ff      <= '0;
         orow_ff      <= '0;
         ocol_ff      <= '0;
         slot_ff      <= '0;
         pos_ff       <= '0;
         fin_ff       <= 1'b0;
         b_valid_ff   <= 1'b0;
         b_end_ff     <= 1'b0;
         b_last_ff    <= 1'b0;
         c_end_ff     <= 1'b0;
         c_last_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wid_ff       <= wid_in;
         hgt_ff       <= hgt_in;
         kw_ff        <= kw_in;
         kh_ff        <= kh_in;
         irow_ff      <= irow_in;
         icol_ff      <= icol_in;
         orow_ff      <= orow_in;
         ocol_ff      <= ocol_in;
         slot_ff      <= slot_in;
         pos_ff       <= pos_in;
         fin_ff       <= fin_in;
         b_valid_ff   <= issue;
         b_end_ff     <= issue && (tj_ff == '0);
         b_last_ff    <= issue && (tj_ff == '0) && (ti_ff == KI_W'(kh_ff - KDIM_W'(1)));
         c_end_ff     <= b_valid_ff && b_end_ff;
         c_last_ff    <= b_valid_ff && b_last_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_row_ff  <= cap_row_in;
      cap_col_ff  <= cap_col_in;
      cap_last_ff <= cap_last_in;
      ti_ff       <= ti_in;
      tj_ff       <= tj_in;
      acc_ff      <= acc_in;
      b_row_ff    <= ti_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== hw/rtl/mbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/mbc_cell.sv =====
// One tap cell: holds a kernel column and adds its product to the partial sum from its neighbor.
`timescale 1ns / 1ps
module mbc_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mbc_pkg::KI_W-1:0]            col_id,
   input  logic                                active,
   input  mbc_pkg::cwr_type                    cwr,
   input  mbc_pkg::tap_type                    tap,
   input  logic [mbc_pkg::PIX_W-1:0]           pixel_in,
   input  logic signed [mbc_pkg::PSUM_W-1:0]   sum_from_right,
   output logic signed [mbc_pkg::PSUM_W-1:0]   sum_out
);
   import mbc_pkg::*;

   logic signed [COEF_W-1:0] coef_ff [MAX_KERNEL];
   logic signed [PSUM_W-1:0] psum_ff;
   logic signed [PSUM_W-1:0] psum_in;
   logic signed [PROD_W-1:0] prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_KERNEL; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (cwr.en && cwr.col == col_id) begin
         coef_ff[cwr.row] <= cwr.value;
      end
   end

   always_comb begin
      prod = $signed({1'b0, pixel_in}) * coef_ff[tap.row];
      psum_in = active ? sum_from_right + PSUM_W'(prod) : '0;
   end

   always_ff @(posedge clock) begin
      if (tap.en) begin
         psum_ff <= psum_in;
      end
   end

   assign sum_out = psum_ff;
endmodule

// ===== tb/mbc_stream_checker.sv =====
// Checker for the mirrored border convolution unit: predicts each output pixel and compares.
`timescale 1ns / 1ps
module mbc_stream_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  mbc_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  mbc_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [mbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbc_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output int                             mismatch_count,
   output int                             pixels_outstanding
);
   import mbc_pkg::*;

   logic signed [COEF_W-1:0] coef_tab [MAX_KERNEL*MAX_KERNEL];
   logic [PIX_W-1:0]         rows_kept [LINE_DEPTH];
   logic [DIM_W-1:0]         width_reg, height_reg;
   logic [KDIM_W-1:0]        kw_reg, kh_reg;
   int                       in_row, in_col, out_row, out_col;
   rsp_type                  expected_pixels [$];

   assign pixels_outstanding = expected_pixels.size();

   function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : int'(v);
   endfunction

   function automatic int fold_coord(input int x, input int n);
      int m;
      m = x;
      if (m < 0) m = -m;
      else if (m >= n) m = 2 * n - 1 - m;
      if (m < 0) m = 0;
      if (m > n - 1) m = n - 1;
      return m;
   endfunction

   task automatic filter_next_pixel(input int w, input int h, input int kw, input int kh);
      longint  acc;
      longint  q;
      int      r, c;
      rsp_type res;
      acc = 0;
      for (int i = 0; i < kh; i++) begin
         r = fold_coord(out_row - kh / 2 + i, h);
         for (int j = 0; j < kw; j++) begin
            c = fold_coord(out_col - kw / 2 + j, w);
            acc += longint'(rows_kept[(r % MAX_KERNEL) * MAX_WIDTH + c]) *
                   longint'(coef_tab[i * MAX_KERNEL + j]);
         end
      end
      q = (acc + 8192) >>> 14;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.value = q[15:0];
      res.last_of_frame = (out_row == h - 1) && (out_col == w - 1);
      expected_pixels.push_back(res);
      if (res.last_of_frame) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else if (++out_col >= w) begin
         out_col = 0;
         out_row++;
      end
   endtask

   task automatic predict_transfer(input req_type d);
      int w, h, kw, kh, pos;
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      kw = int'(kw_reg);
      kh = int'(kh_reg);
      case (d.mode)
         MODE_COEF: begin
            if (d.coef_index < MAX_KERNEL * MAX_KERNEL) coef_tab[d.coef_index] = d.coef_value;
         end
         MODE_PIXEL: begin
            if (in_row < h) begin
               rows_kept[(in_row % MAX_KERNEL) * MAX_WIDTH + in_col] = d.pixel;
               pos = in_row * w + in_col;
               if (++in_col >= w) begin
                  in_col = 0;
                  in_row++;
               end
               if (pos >= (kh / 2) * w + kw / 2) filter_next_pixel(w, h, kw, kh);
            end
         end
         MODE_FLUSH: begin
            if (in_row >= h) filter_next_pixel(w, h, kw, kh);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (coef_tab[k]) coef_tab[k] = '0;
         foreach (rows_kept[k]) rows_kept[k] = '0;
         width_reg = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         kw_reg = RESET_KW;
         kh_reg = RESET_KH;
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         expected_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t unexpected output pixel value=%0d last=%0b", $realtime,
                           rsp_data.value, rsp_data.last_of_frame);
            end else begin
               if (rsp_data.value !== expected_pixels[0].value ||
                   rsp_data.last_of_frame !== expected_pixels[0].last_of_frame) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t pixel mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
                              $realtime, expected_pixels[0].value,
                              expected_pixels[0].last_of_frame, rsp_data.value,
                              rsp_data.last_of_frame);
               end
               void'(expected_pixels.pop_front());
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   width_reg = csr_wdata;
               CSR_IMAGE_HEIGHT:  height_reg = csr_wdata;
               CSR_KERNEL_WIDTH:  kw_reg = csr_wdata[KDIM_W-1:0];
               CSR_KERNEL_HEIGHT: kh_reg = csr_wdata[KDIM_W-1:0];
               default: ;
            endcase
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         end
         if (req_valid && req_ready) predict_transfer(req_data);
      end
   end

endmodule

// ===== tb/mirrored_border_2d_convolution_unit_tb.sv =====
// Testbench top of the mirrored border convolution unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module mirrored_border_2d_convolution_unit_tb;
   import mbc_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 64;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   int                   mismatch_count;
   int                   pixels_outstanding;

   bit                   calm = 1'b0;
   bit                   hold_request = 1'b0;
   int                   hold_left = 0;
   int                   items_sent = 0;

   always #2 clock = ~clock;

   mirrored_border_2d_convolution_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   mbc_stream_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pixels_outstanding(pixels_outstanding)
   );

   // The output side stalls at random unless calm is set, or holds off completely when asked.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   initial begin
      #4_000_000;
      $display("mirrored_border_2d_convolution_unit_tb: errors");
      $finish;
   end

   function automatic req_type make_item(input logic [1:0] mode, input logic [5:0] idx,
                                         input logic [15:0] coef, input logic [7:0] pix);
      req_type d;
      d.mode = mode;
      d.coef_index = idx;
      d.coef_value = coef;
      d.pixel = pix;
      return d;
   endfunction

   function automatic req_type random_item(input logic [1:0] mode);
      return make_item(mode, 6'($urandom), 16'($urandom), 8'($urandom));
   endfunction

   task automatic push(input req_type d);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int kw, input int kh);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;   csr_wdata <= CSR_DAT_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;  csr_wdata <= CSR_DAT_W'(h);
      @(posedge clock);
      csr_index <= CSR_KERNEL_WIDTH;  csr_wdata <= CSR_DAT_W'(kw);
      @(posedge clock);
      csr_index <= CSR_KERNEL_HEIGHT; csr_wdata <= CSR_DAT_W'(kh);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Style 0 is full range, 1 is moderate taps, 2 is the extremes only.
   task automatic load_kernel(input int style);
      logic [15:0] v;
      for (int k = 0; k < MAX_KERNEL * MAX_KERNEL; k++) begin
         case (style)
            0:       v = 16'($urandom);
            1:       v = 16'($urandom_range(0, 4096) - 2048);
            default: v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
         endcase
         push(make_item(MODE_COEF, 6'(k), v, 8'($urandom)));
      end
   endtask

   task automatic run_frame(input int w, input int h, input int kw, input int kh,
                            input bit noisy);
      int ew, eh, lag, total, flushes;
      configure(w, h, kw, kh);
      ew = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      eh = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
      lag = (kh / 2) * ew + kw / 2;
      total = ew * eh;
      flushes = (lag < total) ? lag : total;
      for (int p = 0; p < total; p++) begin
         if (noisy && $urandom_range(99) < 6) begin
            case ($urandom_range(2))
               0: push(random_item(MODE_UNUSED));
               1: push(random_item(MODE_COEF));
               default: push(random_item(MODE_FLUSH));
            endcase
         end
         push(make_item(MODE_PIXEL, 6'($urandom), 16'($urandom),
                        ($urandom_range(9) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom)));
      end
      if (flushes > 0 && noisy) begin
         repeat ($urandom_range(0, 2)) push(random_item(MODE_PIXEL));
         push(random_item(MODE_UNUSED));
      end
      repeat (flushes) push(random_item(MODE_FLUSH));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push(make_item(MODE_COEF, 6'd0, 16'h7FFF, 8'd0));
      push(make_item(MODE_COEF, 6'd48, 16'h8000, 8'hFF));
      push(make_item(MODE_COEF, 6'd63, 16'h1234, 8'd0));
      push(make_item(MODE_UNUSED, 6'd5, 16'h4000, 8'd7));
      push(make_item(MODE_FLUSH, 6'd0, 16'd0, 8'd0));
      push(make_item(MODE_COEF, 6'd24, 16'h4000, 8'd0));
      run_frame(3, 2, 3, 3, 1'b0);
      run_frame(0, 0, 7, 7, 1'b0);
      run_frame(2, 3, 0, 0, 1'b0);
      load_kernel(2);
      run_frame(2, 2, 7, 7, 1'b0);
      load_kernel(0);
      run_frame(13, 1, 1, 1, 1'b0);
      run_frame(5, 24, 2, 4, 1'b0);

      for (int f = 0; items_sent < 1200; f++) begin
         if (f % 6 == 0) load_kernel($urandom_range(9) < 6 ? 1 : $urandom_range(2) / 2 * 2);
         calm = (f >= 8 && f < 14);
         if (f % 15 == 3) hold_request = 1'b1;
         run_frame($urandom_range(0, 12), $urandom_range(0, 9), $urandom_range(0, 7),
                   $urandom_range(0, 7), $urandom_range(3) != 0);
      end
      calm = 1'b0;
      drain();

      if (mismatch_count == 0) begin
         $display("mirrored_border_2d_convolution_unit_tb: clean");
      end else begin
         $display("mirrored_border_2d_convolution_unit_tb: errors");
      end
      $finish;
   end

endmodule
